// ===== src/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
// No dependencies.
package fbpa_pkg;

  localparam int FIELD_BITS = 48;

  typedef logic [FIELD_BITS-1:0] field_addr_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

endpackage

// ===== src/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: LIFO free list of chunk indices held in one
// synchronous link memory with a registered read.
// Depends on fbpa_pkg.
//
// An alloc is accepted in ST_IDLE, reads the head entry from the link memory and
// registers its result in ST_ALLOC. A free registers the range check and offset,
// turns the offset into a chunk index by a reciprocal multiply registered in
// ST_FIDX, and registers its result in ST_FCOMMIT. busy is high in these states,
// so a new item is accepted only once the previous one is done.
// After reset the link memory is initialized entry by entry in ST_INIT with busy high.
// The done strobe lasts one cycle; the receiver cannot stall it.
module fixed_block_pool_allocator #(
  parameter int POOL_ENTRIES = 256,
  parameter int CHUNK_BYTES  = 16,
  parameter int HEADER_BYTES = 8,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 config_write,
  input  fbpa_pkg::field_addr_t config_data,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  fbpa_pkg::field_addr_t free_address,
  output logic                 done,
  output fbpa_pkg::field_addr_t object_address,
  output logic                 ok
);
  import fbpa_pkg::*;

  localparam int IW    = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CBW   = $clog2(CHUNK_BYTES + 1);
  localparam int CL    = $clog2(CHUNK_BYTES);
  localparam longint unsigned SPAN = longint'(POOL_ENTRIES) * longint'(CHUNK_BYTES);
  localparam int OFFW  = $clog2(SPAN);
  localparam int SHIFT = OFFW + CL;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(CHUNK_BYTES) - 64'd1) / longint'(CHUNK_BYTES);
  localparam int RECIPW = OFFW + 2;
  localparam int PRODW  = OFFW + RECIPW;
  localparam int MULW   = IW + CBW;
  localparam int SW     = FIELD_BITS + 2;
  localparam int MASK_BITS = (ADDRESS_BITS < FIELD_BITS) ? ADDRESS_BITS : FIELD_BITS;
  localparam field_addr_t ADDR_MASK = FIELD_BITS'((65'd1 << MASK_BITS) - 65'd1);

  typedef struct packed {
    logic          last;
    logic [IW-1:0] link;
  } link_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_FIDX,
    ST_FCOMMIT
  } state_t;

  state_t        state;
  field_addr_t   pool_base;
  logic [IW-1:0] head;
  logic          empty;
  logic [IW-1:0] init_cnt;
  logic          in_range;
  logic [OFFW-1:0] offset;
  logic [IW-1:0] idx;

  link_t         mem [POOL_ENTRIES];
  link_t         rd_data;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  link_t         mem_wdata;

  logic            accept;
  logic [SW-1:0]   addr_ext;
  logic [SW-1:0]   first_ext;
  logic [SW-1:0]   end_ext;
  logic [SW-1:0]   offset_full;
  logic [PRODW-1:0] prod;
  logic [MULW-1:0] head_off;
  logic [MULW-1:0] idx_off;
  logic [SW-1:0]   alloc_sum;
  logic            free_ok;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    addr_ext    = SW'(free_address);
    first_ext   = SW'(pool_base) + SW'(HEADER_BYTES);
    end_ext     = SW'(pool_base) + SW'(SPAN);
    offset_full = addr_ext - first_ext;
    prod        = PRODW'(offset) * PRODW'(RECIP);
    head_off    = MULW'(head) * MULW'(CHUNK_BYTES);
    idx_off     = MULW'(idx) * MULW'(CHUNK_BYTES);
    alloc_sum   = SW'(pool_base) + SW'(HEADER_BYTES) + SW'(head_off);
    free_ok     = in_range && (idx_off == MULW'(offset)) && (empty || idx != head);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = init_cnt;
    mem_wdata = '{last: 1'b1, link: '0};
    if (state == ST_INIT) begin
      mem_we = 1'b1;
      if (init_cnt != '0) begin
        mem_wdata = '{last: 1'b0, link: init_cnt - IW'(1)};
      end
    end else if (state == ST_FCOMMIT && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = idx;
      mem_wdata = empty ? '{last: 1'b1, link: '0} : '{last: 1'b0, link: head};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      pool_base <= '0;
      head      <= IW'(POOL_ENTRIES - 1);
      empty     <= 1'b0;
      init_cnt  <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (config_write) begin
        pool_base <= config_data;
      end
      unique case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + IW'(1);
          if (init_cnt == IW'(POOL_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (cmd_t'(command) == CMD_ALLOC) begin
              state <= ST_ALLOC;
            end else begin
              in_range <= (addr_ext >= first_ext) && (addr_ext < end_ext);
              offset   <= offset_full[OFFW-1:0];
              state    <= ST_FIDX;
            end
          end
        end
        ST_ALLOC: begin
          done  <= 1'b1;
          ok    <= !empty;
          state <= ST_IDLE;
          if (empty) begin
            object_address <= '0;
          end else begin
            object_address <= alloc_sum[FIELD_BITS-1:0] & ADDR_MASK;
            if (rd_data.last) begin
              empty <= 1'b1;
            end else begin
              head <= rd_data.link;
            end
          end
        end
        ST_FIDX: begin
          idx   <= prod[SHIFT +: IW];
          state <= ST_FCOMMIT;
        end
        ST_FCOMMIT: begin
          done           <= 1'b1;
          ok             <= free_ok;
          object_address <= '0;
          state          <= ST_IDLE;
          if (free_ok) begin
            head  <= idx;
            empty <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for fixed_block_pool_allocator: directed table, then phases of random
// alloc/free items under several pool base settings, checked against a free-list predictor.
// Depends on fbpa_pkg and the allocator RTL.
module tb;
  import fbpa_pkg::*;

  localparam int POOL_N = 256;
  localparam int CHUNK  = 16;
  localparam int HDR    = 8;
  localparam int SETTLE = 4;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        config_write = 1'b0;
  field_addr_t config_data  = '0;
  logic        start        = 1'b0;
  logic        command      = CMD_ALLOC;
  field_addr_t free_address = '0;
  logic        busy;
  logic        done;
  field_addr_t object_address;
  logic        ok;

  fixed_block_pool_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .config_write  (config_write),
    .config_data   (config_data),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .free_address  (free_address),
    .done          (done),
    .object_address(object_address),
    .ok            (ok)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    field_addr_t addr;
    logic        ok;
  } alloc_result_t;

  typedef struct packed {
    bit          late;
    cmd_t        cmd;
    field_addr_t addr;
    bit          chk;
    field_addr_t exp_addr;
    logic        exp_ok;
  } dir_row_t;

  // late rows run at the last phase (base 0): repeated frees of list members corrupt
  // the list into a cycle, so they come after the empty-list behavior is covered
  localparam int DIR_N = 23;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b0, CMD_ALLOC, 48'd0,               1'b1, 48'd4088, 1'b1},
    '{1'b0, CMD_ALLOC, 48'hFFFF_FFFF_FFFF,  1'b1, 48'd4072, 1'b1},
    '{1'b0, CMD_FREE,  48'd4088,            1'b1, 48'd0,    1'b1},
    '{1'b0, CMD_FREE,  48'd4088,            1'b1, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'd0,               1'b1, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'hFFFF_FFFF_FFFF,  1'b1, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'h8000_0000_0000,  1'b1, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'd4,               1'b1, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'd4096,            1'b1, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'd4089,            1'b1, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'd4072,            1'b1, 48'd0,    1'b1},
    '{1'b0, CMD_ALLOC, 48'd0,               1'b1, 48'd4072, 1'b1},
    '{1'b0, CMD_ALLOC, 48'd0,               1'b1, 48'd4088, 1'b1},
    '{1'b0, CMD_FREE,  48'd16,              1'b0, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'd4080,            1'b0, 48'd0,    1'b0},
    '{1'b0, CMD_FREE,  48'd4088,            1'b0, 48'd0,    1'b0},
    '{1'b0, CMD_ALLOC, 48'd0,               1'b0, 48'd0,    1'b0},
    '{1'b1, CMD_FREE,  48'd120,             1'b0, 48'd0,    1'b0},
    '{1'b1, CMD_FREE,  48'd152,             1'b0, 48'd0,    1'b0},
    '{1'b1, CMD_FREE,  48'd120,             1'b0, 48'd0,    1'b0},
    '{1'b1, CMD_ALLOC, 48'd0,               1'b0, 48'd0,    1'b0},
    '{1'b1, CMD_ALLOC, 48'd0,               1'b0, 48'd0,    1'b0},
    '{1'b1, CMD_ALLOC, 48'd0,               1'b0, 48'd0,    1'b0}
  };

  alloc_result_t result_q [$];
  int            mismatches = 0;

  // free-list model
  field_addr_t pool_base_m;
  int          head_m;
  bit          empty_m;
  int          link_m [POOL_N];
  bit          end_m  [POOL_N];
  int          held [$];

  function automatic field_addr_t chunk_addr(int idx);
    return field_addr_t'(64'(pool_base_m) + 64'(HDR) + 64'(idx) * 64'(CHUNK));
  endfunction

  task automatic pool_predict(input cmd_t cmd, input field_addr_t a, output alloc_result_t r);
    logic [63:0] base64;
    logic [63:0] addr64;
    logic [63:0] first;
    logic [63:0] off;
    logic [63:0] idx;
    base64 = 64'(pool_base_m);
    addr64 = 64'(a);
    first  = base64 + 64'(HDR);
    r      = '0;
    if (cmd == CMD_ALLOC) begin
      if (!empty_m) begin
        r.addr = chunk_addr(head_m);
        r.ok   = 1'b1;
        held.push_back(head_m);
        if (end_m[head_m]) empty_m = 1'b1;
        else head_m = link_m[head_m];
      end
    end else if (addr64 > base64 && addr64 < base64 + 64'(POOL_N * CHUNK) &&
                 addr64 >= first) begin
      off = addr64 - first;
      idx = off / 64'(CHUNK);
      if (off % 64'(CHUNK) == 0 && idx < 64'(POOL_N) && (empty_m || int'(idx) != head_m)) begin
        link_m[idx] = empty_m ? 0 : head_m;
        end_m[idx]  = empty_m;
        head_m      = int'(idx);
        empty_m     = 1'b0;
        r.ok        = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result addr %h ok %b", $time, object_address, ok);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (object_address !== want.addr) begin
          $display("%0t: object_address expected %h got %h", $time, want.addr, object_address);
          mismatches++;
        end
        if (ok !== want.ok) begin
          $display("%0t: ok expected %b got %b", $time, want.ok, ok);
          mismatches++;
        end
      end
    end
  end

  task automatic send_item(input cmd_t cmd, input field_addr_t a, input bit chk,
                           input field_addr_t exp_addr, input logic exp_ok);
    alloc_result_t r;
    start        <= 1'b1;
    command      <= cmd;
    free_address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    pool_predict(cmd, a, r);
    if (chk) r = {exp_addr, exp_ok};
    result_q.push_back(r);
  endtask

  task automatic idle_gap(input bit no_gap);
    int r;
    int g;
    r = $urandom_range(0, 99);
    g = 0;
    if (!no_gap) begin
      if (r >= 90) g = $urandom_range(4, 40);
      else if (r >= 60) g = $urandom_range(1, 3);
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_base(input field_addr_t v);
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    config_write <= 1'b1;
    config_data  <= v;
    @(posedge clk);
    pool_base_m = v;
    config_write <= 1'b0;
  endtask

  task automatic walk_table(input bit late);
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].late == late) begin
        idle_gap(1'b0);
        send_item(DIR_TAB[i].cmd, DIR_TAB[i].addr, DIR_TAB[i].chk,
                  DIR_TAB[i].exp_addr, DIR_TAB[i].exp_ok);
      end
    end
    start <= 1'b0;
  endtask

  task automatic run_phase(input int alloc_pct, input int n, input bit dup_ok, input bit no_gap);
    int          k;
    int          j;
    field_addr_t a;
    for (int i = 0; i < n; i++) begin
      idle_gap(no_gap);
      k = $urandom_range(0, 99);
      if (k < alloc_pct) begin
        send_item(CMD_ALLOC, field_addr_t'({$urandom(), $urandom()}), 1'b0, '0, 1'b0);
      end else begin
        k = $urandom_range(0, 99);
        if (held.size() > 0 && k < 70) begin
          j = $urandom_range(0, held.size() - 1);
          a = chunk_addr(held[j]);
          held.delete(j);
        end else if (dup_ok && k < 80) begin
          a = chunk_addr($urandom_range(0, POOL_N - 1));
        end else if (k < 90) begin
          a = field_addr_t'({$urandom(), $urandom()});
        end else begin
          a = chunk_addr($urandom_range(0, POOL_N)) + field_addr_t'($urandom_range(0, 16)) - 48'd8;
        end
        send_item(CMD_FREE, a, 1'b0, '0, 1'b0);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    field_addr_t base;
    int          pct;
    int          n;
    bit          dup_ok;
    bit          no_gap;
    pool_base_m = '0;
    head_m      = POOL_N - 1;
    empty_m     = 1'b0;
    for (int i = 0; i < POOL_N; i++) begin
      link_m[i] = (i == 0) ? 0 : i - 1;
      end_m[i]  = (i == 0);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    write_base('0);
    walk_table(1'b0);
    for (int p = 0; p < 6; p++) begin
      dup_ok = 1'b0;
      no_gap = 1'b0;
      case (p)
        0: begin base = '0; pct = 50; n = 220; end
        1: begin base = field_addr_t'({$urandom(), $urandom()}); pct = 97; n = 350; no_gap = 1'b1; end
        2: begin base = 48'hFFFF_FFFF_FFFF; pct = 40; n = 150; end
        3: begin base = 48'hFFFF_FFFF_F800; pct = 20; n = 250; end
        4: begin base = field_addr_t'({$urandom(), $urandom()}); pct = 60; n = 250; end
        default: begin base = '0; pct = 50; n = 280; dup_ok = 1'b1; end
      endcase
      write_base(base);
      if (p == 5) walk_table(1'b1);
      run_phase(pct, n, dup_ok, no_gap);
    end
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
